@@ hw/rtl/mtv_pkg.sv @@
// Shared types, constants and command/status structs of the token verifier.
`default_nettype none

package mtv_pkg;

  // Widths of the request fields and of the arithmetic word
  localparam int unsigned FIELD_BITS   = 32;
  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned CNT_BITS     = $clog2(WORD_BITS);
  localparam int unsigned CFG_IDX_BITS = 1;

  typedef logic [FIELD_BITS-1:0]   field_t;
  typedef logic [WORD_BITS-1:0]    word_t;
  typedef logic [CNT_BITS-1:0]     mul_cnt_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t CFG_EXPONENT = CFG_IDX_BITS'(0);
  localparam cfg_idx_t CFG_MODULUS  = CFG_IDX_BITS'(1);

  // Register values after reset
  localparam word_t EXPONENT_RESET = WORD_BITS'(7);
  localparam word_t MODULUS_RESET  = WORD_BITS'(9);

  // Operand selection of the shared modular multiplier
  typedef enum logic [1:0] {
    MUL_REDUCE,   // 1 * user_id mod m : reduce the identifier
    MUL_ACC,      // acc * sq mod m
    MUL_SQUARE    // sq * sq mod m
  } mul_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;       // capture request, seed accumulator and exponent
    logic     mul_start;  // launch one modular multiplication
    mul_sel_t mul_sel;    // which product to form
    logic     exp_shift;  // step to the next exponent bit
    logic     publish;    // write the result registers
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mul_done;   // last cycle of a multiplication
    logic exp_zero;   // no exponent bits left
    logic exp_lsb;    // current exponent bit
    logic mod_zero;   // configured modulus is zero
  } dp_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/mtv_datapath.sv @@
// Datapath: configuration registers, shift-add modular multiplier and result registers.
`default_nettype none

module mtv_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire mtv_pkg::cfg_idx_t cfg_index,
  input  wire mtv_pkg::field_t   cfg_wdata,
  input  wire mtv_pkg::field_t   in_user_id,
  input  wire mtv_pkg::field_t   in_token,
  input  wire mtv_pkg::dp_cmd_t  cmd,
  output mtv_pkg::dp_sts_t       sts,
  output mtv_pkg::field_t        out_expected,
  output logic                   out_approved,
  output logic                   out_bad_modulus
);

  localparam int unsigned W = mtv_pkg::WORD_BITS;

  mtv_pkg::word_t   exponent_r, exponent_nxt;
  mtv_pkg::word_t   modulus_r, modulus_nxt;
  mtv_pkg::word_t   id_r, token_r, exp_r, acc_r, sq_r;
  mtv_pkg::word_t   mul_a_r, mul_b_r, mul_p_r, mul_res;
  mtv_pkg::mul_cnt_t mul_cnt_r;
  logic             mul_busy_r;
  mtv_pkg::mul_sel_t mul_sel_r;
  logic [W+1:0]     m_ext, m_dbl, t_sum, t_m1, t_m2;
  logic             mul_done;
  mtv_pkg::word_t   exp_word;
  mtv_pkg::field_t  out_expected_r;
  logic             out_approved_r, out_bad_r;

  // Decode configuration writes; unknown indexes leave the registers alone
  always_comb begin
    exponent_nxt = exponent_r;
    modulus_nxt  = modulus_r;
    if (cfg_we) begin
      case (cfg_index)
        mtv_pkg::CFG_EXPONENT: exponent_nxt = cfg_wdata[W-1:0];
        mtv_pkg::CFG_MODULUS:  modulus_nxt  = cfg_wdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r <= mtv_pkg::EXPONENT_RESET;
      modulus_r  <= mtv_pkg::MODULUS_RESET;
    end else begin
      exponent_r <= exponent_nxt;
      modulus_r  <= modulus_nxt;
    end
  end

  // One multiplier bit per cycle: double, add, then fold back below m
  always_comb begin
    m_ext = {2'b00, modulus_r};
    m_dbl = {1'b0, modulus_r, 1'b0};
    t_sum = {1'b0, mul_p_r, 1'b0} + (mul_b_r[W-1] ? {2'b00, mul_a_r} : '0);
    t_m1  = t_sum - m_ext;
    t_m2  = t_sum - m_dbl;
    if (t_sum >= m_dbl) begin
      mul_res = t_m2[W-1:0];
    end else if (t_sum >= m_ext) begin
      mul_res = t_m1[W-1:0];
    end else begin
      mul_res = t_sum[W-1:0];
    end
  end

  assign mul_done = mul_busy_r && (mul_cnt_r == mtv_pkg::CNT_BITS'(W - 1));

  // Multiplier control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mul_cnt_r  <= '0;
    end else if (cmd.mul_start) begin
      mul_busy_r <= 1'b1;
      mul_cnt_r  <= '0;
    end else if (mul_busy_r) begin
      mul_busy_r <= !mul_done;
      mul_cnt_r  <= mul_cnt_r + mtv_pkg::CNT_BITS'(1);
    end
  end

  // Load operands on launch, otherwise advance the partial product
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mul_sel_r <= cmd.mul_sel;
      mul_p_r   <= '0;
      case (cmd.mul_sel)
        mtv_pkg::MUL_REDUCE: begin
          mul_a_r <= W'(1);
          mul_b_r <= id_r;
        end
        mtv_pkg::MUL_ACC: begin
          mul_a_r <= acc_r;
          mul_b_r <= sq_r;
        end
        mtv_pkg::MUL_SQUARE: begin
          mul_a_r <= sq_r;
          mul_b_r <= sq_r;
        end
        default: begin
          mul_a_r <= sq_r;
          mul_b_r <= sq_r;
        end
      endcase
    end else if (mul_busy_r) begin
      mul_p_r <= mul_res;
      mul_b_r <= {mul_b_r[W-2:0], 1'b0};
    end
  end

  // Capture the request and keep accumulator, square and exponent bits
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r    <= in_user_id[W-1:0];
      token_r <= in_token[W-1:0];
      exp_r   <= exponent_r;
      acc_r   <= (modulus_r == W'(1)) ? '0 : W'(1);
    end else begin
      if (cmd.exp_shift) begin
        exp_r <= exp_r >> 1;
      end
      if (mul_done) begin
        if (mul_sel_r == mtv_pkg::MUL_ACC) begin
          acc_r <= mul_res;
        end else begin
          sq_r <= mul_res;
        end
      end
    end
  end

  // Result registers, written once per request
  assign exp_word = sts.mod_zero ? '0 : acc_r;

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_expected_r <= mtv_pkg::FIELD_BITS'(exp_word);
      out_approved_r <= !sts.mod_zero && (token_r == acc_r);
      out_bad_r      <= sts.mod_zero;
    end
  end

  always_comb begin
    sts.mul_done = mul_done;
    sts.exp_zero = (exp_r == '0);
    sts.exp_lsb  = exp_r[0];
    sts.mod_zero = (modulus_r == '0);
  end

  assign out_expected    = out_expected_r;
  assign out_approved    = out_approved_r;
  assign out_bad_modulus = out_bad_r;

endmodule

`default_nettype wire

@@ hw/rtl/mtv_ctrl.sv @@
// Controller: sequences reduction and square-and-multiply, owns the request handshakes.
`default_nettype none

module mtv_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire mtv_pkg::dp_sts_t sts,
  output mtv_pkg::dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT_RED,
    ST_BIT,
    ST_WAIT_ACC,
    ST_WAIT_SQ,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_accept, out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.mul_sel   = mtv_pkg::MUL_SQUARE;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          cmd.load  = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        // Skip the arithmetic altogether on a zero modulus
        if (sts.mod_zero) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = mtv_pkg::MUL_REDUCE;
          state_nxt     = ST_WAIT_RED;
        end
      end
      ST_WAIT_RED: begin
        if (sts.mul_done) begin
          state_nxt = ST_BIT;
        end
      end
      ST_BIT: begin
        if (sts.exp_zero) begin
          state_nxt = ST_FINISH;
        end else if (sts.exp_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = mtv_pkg::MUL_ACC;
          state_nxt     = ST_WAIT_ACC;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = mtv_pkg::MUL_SQUARE;
          state_nxt     = ST_WAIT_SQ;
        end
      end
      ST_WAIT_ACC: begin
        if (sts.mul_done) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = mtv_pkg::MUL_SQUARE;
          state_nxt     = ST_WAIT_SQ;
        end
      end
      ST_WAIT_SQ: begin
        if (sts.mul_done) begin
          cmd.exp_shift = 1'b1;
          state_nxt     = ST_BIT;
        end
      end
      ST_FINISH: begin
        // Hold until the result register is free
        if (out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_publish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_valid_r || !out_stall))
    else $error("result written over a request not yet taken");

  a_accept_then_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_START))
    else $error("accepted request did not start");

  a_no_stray_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_START || state_r == ST_BIT ||
     state_r == ST_FINISH) |-> !sts.mul_done)
    else $error("multiplier finished outside a wait state");

  a_finish_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_free) |=> (state_r == ST_IDLE && out_valid_r))
    else $error("finished request not published");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/modexp_token_verifier_core.sv @@
// Top level of the modular-exponentiation token verifier.
`default_nettype none

// Each request (user_id, token) yields one result: expected = user_id^exponent
// mod modulus, approved when the token matches, and bad_modulus when the
// modulus register is zero (expected and approved are then 0). One request is
// in work at a time; the next is taken while a finished result still waits on
// the output register. All arithmetic runs through one shift-add modular
// multiplier that retires one multiplier bit per cycle. A request first
// reduces user_id mod modulus, then, for each exponent bit up to the highest
// set one, multiplies the accumulator by the square when the bit is set and
// then squares; on a zero modulus the arithmetic is skipped. The result
// appears in the same cycle in which the next request can be taken.
// Configuration writes (index 0 exponent, index 1 modulus) are taken at any
// time but must only be issued while the block is idle.
module modexp_token_verifier_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire mtv_pkg::cfg_idx_t cfg_index,
  input  wire mtv_pkg::field_t   cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mtv_pkg::field_t   in_user_id,
  input  wire mtv_pkg::field_t   in_token,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mtv_pkg::field_t        out_expected,
  output logic                   out_approved,
  output logic                   out_bad_modulus
);

  mtv_pkg::dp_cmd_t cmd;
  mtv_pkg::dp_sts_t sts;

  mtv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mtv_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_user_id      (in_user_id),
    .in_token        (in_token),
    .cmd             (cmd),
    .sts             (sts),
    .out_expected    (out_expected),
    .out_approved    (out_approved),
    .out_bad_modulus (out_bad_modulus)
  );

endmodule

`default_nettype wire
